// ----- sv/lpb_pkg.sv -----
// shared types and constants of the led strip pixel buffer
`default_nettype none
package lpb_pkg;

  localparam int MAX_PIXELS   = 256;
  localparam int MAX_CHANNELS = 5;
  localparam int STORE_DEPTH  = MAX_PIXELS * MAX_CHANNELS;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int FULL_SCALE   = 256;
  localparam int SCALE_W      = $clog2(FULL_SCALE) + 1;
  localparam int PROD_W       = 8 + SCALE_W;
  localparam int SHIFT        = $clog2(FULL_SCALE);

  typedef logic [7:0] byte_t;
  typedef logic [2:0] code_t;

  // channel codes held by the order registers
  localparam code_t CH_RED  = 3'd0;
  localparam code_t CH_WARM = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_PIXEL_COUNT   = 3'd0;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd1;
  localparam logic [2:0] REG_ORDER_SLOT0   = 3'd2;

  typedef enum logic [1:0] {
    FN_SET_PIXEL  = 2'd0,
    FN_SET_ALL    = 2'd1,
    FN_SCALE_ALL  = 2'd2,
    FN_READ_PIXEL = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0]                   pix_cnt;
    logic [2:0]                   ch_cnt;   // already clamped to 1..MAX_CHANNELS
    logic [MAX_CHANNELS-1:0][2:0] order;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    byte_t             wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// ----- sv/lpb_if.sv -----
// item channels of the led strip pixel buffer
`default_nettype none
interface lpb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] cold_white;
  logic [7:0] warm_white;
  logic [8:0] scale_factor;

  modport source (output valid, func, pixel_index, red, green, blue, cold_white,
                  warm_white, scale_factor, input ready);
  modport sink (input valid, func, pixel_index, red, green, blue, cold_white,
                warm_white, scale_factor, output ready);
endinterface

interface lpb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic       status;

  modport source (output valid, byte0, byte1, byte2, byte3, byte4, status, input ready);
  modport sink (input valid, byte0, byte1, byte2, byte3, byte4, status, output ready);
endinterface
`default_nettype wire

// ----- sv/lpb_cfg.sv -----
// configuration registers with channel count clamping
`default_nettype none
module lpb_cfg
  import lpb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  output cfg_t            cfg
);

  logic [7:0]                   pix_cnt_r;
  logic [2:0]                   ch_cnt_r;
  logic [MAX_CHANNELS-1:0][2:0] order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r <= '0;
      ch_cnt_r  <= 3'd3;
      for (int s = 0; s < MAX_CHANNELS; s++) begin
        order_r[s] <= 3'(s);
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_PIXEL_COUNT) begin
        pix_cnt_r <= cfg_wdata;
      end
      if (cfg_index == REG_CHANNEL_COUNT) begin
        ch_cnt_r <= cfg_wdata[2:0];
      end
      for (int s = 0; s < MAX_CHANNELS; s++) begin
        if (cfg_index == 3'(REG_ORDER_SLOT0 + s)) begin
          order_r[s] <= cfg_wdata[2:0];
        end
      end
    end
  end

  always_comb begin
    cfg.pix_cnt = pix_cnt_r;
    cfg.order   = order_r;
    if (ch_cnt_r == 3'd0) begin
      cfg.ch_cnt = 3'd1;
    end else if (ch_cnt_r > 3'(MAX_CHANNELS)) begin
      cfg.ch_cnt = 3'(MAX_CHANNELS);
    end else begin
      cfg.ch_cnt = ch_cnt_r;
    end
  end

endmodule
`default_nettype wire

// ----- sv/lpb_mem.sv -----
// pixel byte store, one write and one registered read per cycle
`default_nettype none
module lpb_mem
  import lpb_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output byte_t         rdata
);

  byte_t mem [STORE_DEPTH];
  byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- sv/lpb_seq.sv -----
// operation sequencer: clear pass, pixel walks, read-modify-write scaling, result register
`default_nettype none
module lpb_seq
  import lpb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  lpb_in_if.sink     in_ch,
  lpb_out_if.source  out_ch,
  output mem_req_t   mem_req,
  input  wire byte_t mem_rdata
);

  state_t state_r, state_nxt;

  func_t              op_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [ADDR_W-1:0]  end_r;
  logic [2:0]         slot_r;
  byte_t              ch_r [MAX_CHANNELS];
  logic [SCALE_W-1:0] scale_r;
  logic               rd_pend_r;
  logic [ADDR_W-1:0]  rd_addr_r;
  logic [2:0]         rd_slot_r;
  byte_t              res_r [MAX_CHANNELS];
  logic               status_r;
  logic               out_valid_r;
  byte_t              out_byte_r [MAX_CHANNELS];
  logic               out_status_r;

  logic [MAX_CHANNELS-1:0] slot_ok;
  logic [ADDR_W-1:0]       base;
  logic [ADDR_W-1:0]       total;
  logic                    accept;
  logic                    walk_go;
  logic                    out_load;
  func_t                   in_func;
  code_t                   cur_code;
  byte_t                   wr_chan;
  logic [PROD_W-1:0]       prod;

  // a slot is written only if it and every lower slot carry a known channel
  always_comb begin
    slot_ok[0] = (cfg.order[0] <= CH_WARM);
    for (int s = 1; s < MAX_CHANNELS; s++) begin
      slot_ok[s] = slot_ok[s-1] && (cfg.order[s] <= CH_WARM);
    end
  end

  assign in_func  = func_t'(in_ch.func);
  assign base     = ADDR_W'(in_ch.pixel_index) * ADDR_W'(cfg.ch_cnt);
  assign total    = ADDR_W'(cfg.pix_cnt) * ADDR_W'(cfg.ch_cnt);
  assign accept   = in_ch.valid && in_ch.ready;
  assign walk_go  = (state_r == ST_WALK) && (addr_r != end_r);
  assign cur_code = cfg.order[slot_r];
  assign wr_chan  = (cur_code <= CH_WARM) ? ch_r[cur_code] : '0;
  assign prod     = PROD_W'(mem_rdata) * PROD_W'(scale_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        if (addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (addr_r == end_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // memory port: clear pass, pixel writes, and scaled write-back in the cycle after the read
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = addr_r;
    mem_req.wdata = '0;
    mem_req.raddr = addr_r;
    if (state_r == ST_CLEAR) begin
      mem_req.we = 1'b1;
    end else if (walk_go && (op_r == FN_SET_PIXEL || op_r == FN_SET_ALL)) begin
      mem_req.we    = slot_ok[slot_r];
      mem_req.wdata = wr_chan;
    end else if (rd_pend_r && op_r == FN_SCALE_ALL) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = rd_addr_r;
      mem_req.wdata = prod[SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      end_r       <= '0;
      slot_r      <= '0;
      rd_pend_r   <= 1'b0;
      op_r        <= FN_SET_PIXEL;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= walk_go && (op_r == FN_SCALE_ALL || op_r == FN_READ_PIXEL);
      if (state_r == ST_CLEAR) begin
        addr_r <= (addr_r == ADDR_W'(STORE_DEPTH - 1)) ? '0 : addr_r + ADDR_W'(1);
      end else if (accept) begin
        op_r   <= in_func;
        slot_r <= '0;
        if (in_func == FN_SET_PIXEL || in_func == FN_READ_PIXEL) begin
          // out of range items run an empty walk
          addr_r <= base;
          end_r  <= (in_ch.pixel_index < cfg.pix_cnt) ? base + ADDR_W'(cfg.ch_cnt) : base;
        end else begin
          addr_r <= '0;
          end_r  <= total;
        end
      end else if (walk_go) begin
        addr_r <= addr_r + ADDR_W'(1);
        slot_r <= (slot_r == cfg.ch_cnt - 3'd1) ? '0 : slot_r + 3'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= addr_r;
    rd_slot_r <= slot_r;
    if (accept) begin
      ch_r[0]  <= in_ch.red;
      ch_r[1]  <= in_ch.green;
      ch_r[2]  <= in_ch.blue;
      ch_r[3]  <= in_ch.cold_white;
      ch_r[4]  <= in_ch.warm_white;
      scale_r  <= (in_ch.scale_factor > SCALE_W'(FULL_SCALE)) ? SCALE_W'(FULL_SCALE)
                                                              : in_ch.scale_factor;
      status_r <= (in_func == FN_SET_PIXEL || in_func == FN_READ_PIXEL) &&
                  (in_ch.pixel_index >= cfg.pix_cnt);
      for (int s = 0; s < MAX_CHANNELS; s++) begin
        res_r[s] <= '0;
      end
    end else if (rd_pend_r && op_r == FN_READ_PIXEL) begin
      res_r[rd_slot_r] <= mem_rdata;
    end
    if (out_load) begin
      out_status_r <= status_r;
      for (int s = 0; s < MAX_CHANNELS; s++) begin
        out_byte_r[s] <= res_r[s];
      end
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.byte0  = out_byte_r[0];
  assign out_ch.byte1  = out_byte_r[1];
  assign out_ch.byte2  = out_byte_r[2];
  assign out_ch.byte3  = out_byte_r[3];
  assign out_ch.byte4  = out_byte_r[4];
  assign out_ch.status = out_status_r;

endmodule
`default_nettype wire

// ----- sv/led_strip_pixel_buffer_top.sv -----
// top level of the led strip pixel buffer
// an item walks its pixel's bytes (all pixel count * channel count bytes for set all and scale all,
//   none for an out of range index), then drains and loads the result register once the output is free
// items are taken one at a time: in_ch.ready is high only while the sequencer is idle
// reset: synchronous, active low; a clearing pass then zeroes all 1280 store bytes, one per
//   cycle, with in_ch.ready low; configuration writes are taken throughout
`default_nettype none
module led_strip_pixel_buffer_top
  import lpb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  lpb_in_if.sink          in_ch,
  lpb_out_if.source       out_ch
);

  cfg_t     cfg;
  mem_req_t mem_req;
  byte_t    mem_rdata;

  lpb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lpb_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  lpb_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule
`default_nettype wire

// ----- verif/tb_led_strip_pixel_buffer_top.sv -----
// testbench of the led strip pixel buffer: directed table then random phases vs a byte-store model
`timescale 1ns / 1ps
module tb_led_strip_pixel_buffer_top
  import lpb_pkg::*;
();

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 78;
  localparam int DRAIN_CYCLES   = 64;

  localparam code_t CH_GREEN = 3'd1;
  localparam code_t CH_BLUE  = 3'd2;
  localparam code_t CH_COLD  = 3'd3;
  localparam code_t CH_BAD   = 3'd5;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  typedef struct packed {
    byte_t           pix_cnt;
    logic [2:0]      ch_cnt;   // raw register value, clamped on use
    logic [0:4][2:0] order;
  } strip_cfg_t;

  typedef struct packed {
    func_t           func;
    byte_t           pixel_index;
    logic [0:4][7:0] chan;     // red, green, blue, cold white, warm white
    logic [8:0]      scale;
  } pix_req_t;

  typedef struct packed {
    logic [0:4][7:0] bytes;
    logic            status;
  } pix_ack_t;

  typedef struct packed {
    logic       is_cfg;
    strip_cfg_t cfg;
    pix_req_t   req;
    logic       typed;
    pix_ack_t   ack;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_wdata;

  lpb_in_if  in_ch ();
  lpb_out_if out_ch ();

  led_strip_pixel_buffer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  strip_cfg_t  model_cfg;
  byte_t       strip_bytes [STORE_DEPTH];
  pix_ack_t    pending_acks [$];
  int unsigned ack_errors = 0;
  int unsigned burst_left = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned channels_in_use();
    if (model_cfg.ch_cnt == 3'd0) return 1;
    if (model_cfg.ch_cnt > MAX_CHANNELS) return MAX_CHANNELS;
    return 32'(model_cfg.ch_cnt);
  endfunction

  // an unknown channel code stops the write at that slot
  function automatic void store_pixel(int unsigned pix, logic [0:4][7:0] chan);
    int unsigned cc;
    cc = channels_in_use();
    for (int unsigned s = 0; s < cc && model_cfg.order[s] <= CH_WARM; s++)
      strip_bytes[pix * cc + s] = chan[model_cfg.order[s]];
  endfunction

  function automatic pix_ack_t apply_pixel_op(pix_req_t req);
    pix_ack_t    ack;
    int unsigned cc;
    int unsigned np;
    int unsigned sc;
    ack = '0;
    cc  = channels_in_use();
    np  = 32'(model_cfg.pix_cnt);
    sc  = (req.scale > FULL_SCALE) ? FULL_SCALE : 32'(req.scale);
    case (req.func)
      FN_SET_PIXEL: begin
        if (req.pixel_index >= np) ack.status = ST_RANGE;
        else store_pixel(32'(req.pixel_index), req.chan);
      end
      FN_SET_ALL: begin
        for (int unsigned p = 0; p < np; p++) store_pixel(p, req.chan);
      end
      FN_SCALE_ALL: begin
        for (int unsigned a = 0; a < np * cc; a++)
          strip_bytes[a] = byte_t'((strip_bytes[a] * sc) / FULL_SCALE);
      end
      default: begin
        if (req.pixel_index >= np) ack.status = ST_RANGE;
        else begin
          for (int unsigned s = 0; s < cc; s++)
            ack.bytes[s] = strip_bytes[32'(req.pixel_index) * cc + s];
        end
      end
    endcase
    return ack;
  endfunction

  function automatic dir_row_t op_row(func_t f, byte_t idx, logic [0:4][7:0] chan,
                                      logic [8:0] sc);
    dir_row_t row;
    row = '0;
    row.req.func        = f;
    row.req.pixel_index = idx;
    row.req.chan        = chan;
    row.req.scale       = sc;
    return row;
  endfunction

  function automatic dir_row_t checked(dir_row_t row, logic [0:4][7:0] bytes, logic st);
    dir_row_t r;
    r = row;
    r.typed      = 1'b1;
    r.ack.bytes  = bytes;
    r.ack.status = st;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(byte_t n, logic [2:0] cc, logic [0:4][2:0] ord);
    dir_row_t row;
    row = '0;
    row.is_cfg      = 1'b1;
    row.cfg.pix_cnt = n;
    row.cfg.ch_cnt  = cc;
    row.cfg.order   = ord;
    return row;
  endfunction

  task automatic send_item(pix_req_t req, logic typed, pix_ack_t ack);
    pix_ack_t    predicted;
    int unsigned gap;
    in_ch.valid        <= 1'b1;
    in_ch.func         <= req.func;
    in_ch.pixel_index  <= req.pixel_index;
    in_ch.red          <= req.chan[0];
    in_ch.green        <= req.chan[1];
    in_ch.blue         <= req.chan[2];
    in_ch.cold_white   <= req.chan[3];
    in_ch.warm_white   <= req.chan[4];
    in_ch.scale_factor <= req.scale;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_pixel_op(req);
    pending_acks.push_back(typed ? ack : predicted);
    @(negedge clk);
    // bursts of items with random gaps, sometimes none
    if (burst_left > 0) burst_left--;
    else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(0, 11);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_config(strip_cfg_t c);
    model_cfg = c;
    cfg_we    <= 1'b1;
    cfg_index <= REG_PIXEL_COUNT;
    cfg_wdata <= c.pix_cnt;
    @(negedge clk);
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_wdata <= 8'(c.ch_cnt);
    @(negedge clk);
    for (int s = 0; s < MAX_CHANNELS; s++) begin
      cfg_index <= REG_ORDER_SLOT0 + 3'(s);
      cfg_wdata <= 8'(c.order[s]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      ack_errors++;
    end
  endtask

  always @(posedge clk) begin
    pix_ack_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_acks.size() == 0) begin
        $error("ack with no item outstanding");
        ack_errors++;
      end else begin
        want = pending_acks.pop_front();
        check_field("byte0", want.bytes[0], out_ch.byte0);
        check_field("byte1", want.bytes[1], out_ch.byte1);
        check_field("byte2", want.bytes[2], out_ch.byte2);
        check_field("byte3", want.bytes[3], out_ch.byte3);
        check_field("byte4", want.bytes[4], out_ch.byte4);
        check_field("status", 8'(want.status), 8'(out_ch.status));
      end
    end
  end

  // receiver: random stall runs, now and then a long run without stalls
  initial begin
    int unsigned run_left;
    out_ch.ready = 1'b0;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (run_left != 0) run_left--;
      else if (out_ch.ready) begin
        out_ch.ready <= 1'b0;
        run_left = $urandom_range(0, 6);
      end else begin
        out_ch.ready <= 1'b1;
        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 11);
      end
    end
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("FAILURE");
    $finish;
  end

  initial begin
    dir_row_t    rows [$];
    strip_cfg_t  rc;
    pix_req_t    rq;
    int unsigned pick;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_PIXEL_COUNT;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FN_SET_PIXEL;
    in_ch.pixel_index  = '0;
    in_ch.red          = '0;
    in_ch.green        = '0;
    in_ch.blue         = '0;
    in_ch.cold_white   = '0;
    in_ch.warm_white   = '0;
    in_ch.scale_factor = '0;

    model_cfg.pix_cnt = 8'd0;
    model_cfg.ch_cnt  = 3'd3;
    model_cfg.order   = {CH_RED, CH_GREEN, CH_BLUE, CH_COLD, CH_WARM};
    foreach (strip_bytes[a]) strip_bytes[a] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset state: no pixels addressable
    rows.push_back(checked(op_row(FN_SET_PIXEL, 8'd0, '1, 9'd0), '0, ST_RANGE));
    rows.push_back(checked(op_row(FN_READ_PIXEL, 8'd0, '0, 9'd0), '0, ST_RANGE));
    rows.push_back(checked(op_row(FN_SET_ALL, 8'd0, '1, 9'd0), '0, ST_OK));
    rows.push_back(checked(op_row(FN_SCALE_ALL, 8'd0, '0, 9'd128), '0, ST_OK));
    // full strip, five channels
    rows.push_back(cfg_row(8'd255, 3'd5, {CH_RED, CH_GREEN, CH_BLUE, CH_COLD, CH_WARM}));
    rows.push_back(checked(op_row(FN_SET_PIXEL, 8'd254,
                                  {8'hff, 8'h00, 8'ha5, 8'h5a, 8'h01}, 9'd0), '0, ST_OK));
    rows.push_back(checked(op_row(FN_READ_PIXEL, 8'd254, '0, 9'd0),
                           {8'hff, 8'h00, 8'ha5, 8'h5a, 8'h01}, ST_OK));
    rows.push_back(checked(op_row(FN_READ_PIXEL, 8'd255, '0, 9'd0), '0, ST_RANGE));
    rows.push_back(checked(op_row(FN_SET_PIXEL, 8'd0, '1, 9'd0), '0, ST_OK));
    rows.push_back(checked(op_row(FN_READ_PIXEL, 8'd0, '0, 9'd0), '1, ST_OK));
    // full scale and above leave the bytes alone
    rows.push_back(checked(op_row(FN_SCALE_ALL, 8'd0, '0, 9'd256), '0, ST_OK));
    rows.push_back(checked(op_row(FN_SCALE_ALL, 8'd0, '0, 9'd511), '0, ST_OK));
    rows.push_back(checked(op_row(FN_READ_PIXEL, 8'd254, '0, 9'd0),
                           {8'hff, 8'h00, 8'ha5, 8'h5a, 8'h01}, ST_OK));
    rows.push_back(checked(op_row(FN_SCALE_ALL, 8'd0, '0, 9'd128), '0, ST_OK));
    rows.push_back(checked(op_row(FN_READ_PIXEL, 8'd254, '0, 9'd0),
                           {8'h7f, 8'h00, 8'h52, 8'h2d, 8'h00}, ST_OK));
    rows.push_back(checked(op_row(FN_SCALE_ALL, 8'd0, '0, 9'd0), '0, ST_OK));
    rows.push_back(checked(op_row(FN_READ_PIXEL, 8'd254, '0, 9'd0), '0, ST_OK));
    // channel count zero acts as one
    rows.push_back(cfg_row(8'd3, 3'd0, {CH_WARM, CH_RED, CH_RED, CH_RED, CH_RED}));
    rows.push_back(checked(op_row(FN_SET_ALL, 8'd0,
                                  {8'h11, 8'h22, 8'h33, 8'h44, 8'hee}, 9'd0), '0, ST_OK));
    rows.push_back(checked(op_row(FN_READ_PIXEL, 8'd2, '0, 9'd0),
                           {8'hee, 8'h00, 8'h00, 8'h00, 8'h00}, ST_OK));
    // channel count above five acts as five, then an unknown code in slot 3
    rows.push_back(cfg_row(8'd3, 3'd7, {CH_RED, CH_GREEN, CH_BLUE, CH_COLD, CH_WARM}));
    rows.push_back(op_row(FN_SET_ALL, 8'd0, {8'ha1, 8'hb2, 8'hc3, 8'hd4, 8'he5}, 9'd0));
    rows.push_back(cfg_row(8'd3, 3'd6, {CH_BLUE, CH_GREEN, CH_RED, CH_BAD, CH_COLD}));
    rows.push_back(op_row(FN_SET_PIXEL, 8'd1, {8'h01, 8'h02, 8'h03, 8'h04, 8'h05}, 9'd0));
    rows.push_back(op_row(FN_READ_PIXEL, 8'd1, '0, 9'd0));
    // one pixel, two channels
    rows.push_back(cfg_row(8'd1, 3'd2, {CH_WARM, CH_COLD, CH_RED, CH_RED, CH_RED}));
    rows.push_back(checked(op_row(FN_SET_ALL, 8'd0,
                                  {8'h00, 8'h00, 8'h00, 8'h81, 8'h80}, 9'd0), '0, ST_OK));
    rows.push_back(checked(op_row(FN_READ_PIXEL, 8'd0, '0, 9'd0),
                           {8'h80, 8'h81, 8'h00, 8'h00, 8'h00}, ST_OK));
    rows.push_back(checked(op_row(FN_READ_PIXEL, 8'd1, '0, 9'd0), '0, ST_RANGE));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_drained();
        write_config(rows[i].cfg);
      end else begin
        send_item(rows[i].req, rows[i].typed, rows[i].ack);
      end
    end

    // random phases: mostly short strips, a few full ones with rare bulk operations
    for (int ph = 0; ph < PHASES; ph++) begin
      rc.pix_cnt = (ph % 5 == 2) ? 8'd255 : 8'($urandom_range(0, 20));
      rc.ch_cnt  = 3'($urandom_range(0, 7));
      for (int s = 0; s < MAX_CHANNELS; s++)
        rc.order[s] = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4));
      wait_drained();
      write_config(rc);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (rc.pix_cnt == 8'd255) begin
          pick = $urandom_range(0, 63);
          rq.func = (pick < 31) ? FN_SET_PIXEL : (pick < 62) ? FN_READ_PIXEL :
                    (pick == 62) ? FN_SCALE_ALL : FN_SET_ALL;
        end else begin
          pick = $urandom_range(0, 19);
          rq.func = (pick < 7) ? FN_SET_PIXEL : (pick < 14) ? FN_READ_PIXEL :
                    (pick < 17) ? FN_SCALE_ALL : FN_SET_ALL;
        end
        rq.pixel_index = (rc.pix_cnt == 8'd0 || $urandom_range(0, 4) == 0) ?
                         8'($urandom_range(0, 255)) : 8'($urandom_range(0, rc.pix_cnt - 1));
        for (int j = 0; j < 5; j++) rq.chan[j] = 8'($urandom_range(0, 255));
        // keep most scales high so the stored data survives
        rq.scale = ($urandom_range(0, 15) == 0) ? 9'($urandom_range(0, 511))
                                                 : 9'($urandom_range(192, 256));
        send_item(rq, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ack_errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/lpb_pkg.sv
sv/lpb_if.sv
sv/lpb_cfg.sv
sv/lpb_mem.sv
sv/lpb_seq.sv
sv/led_strip_pixel_buffer_top.sv
verif/tb_led_strip_pixel_buffer_top.sv
